// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rtl; ASSERT_OFF removes them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every edge while not disabled
`define ASSERT_ALWAYS(label, clk, dis, cond) \
  label: assert property (@(posedge clk) disable iff (dis) (cond)) \
    else $error("assertion failed: label");

// antecedent at one edge gives consequent at the next
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// antecedent gives consequent at the same edge
`define ASSERT_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, dis, cond)
`define ASSERT_NEXT(label, clk, dis, ante, cons)
`define ASSERT_IMPL(label, clk, dis, ante, cons)

`endif

`endif

// File: design/dtyp_pkg.sv
// ----------------------------------------------------------------------------
// dtyp_pkg
// shared constants, control struct and arctangent table for the
// direction to yaw/pitch cordic pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package dtyp_pkg;

  // fractional guard bits added to each component
  localparam int GUARD_BITS   = 4;
  // headroom for cordic gain over two passes and vector length
  localparam int GROWTH_BITS  = 5;
  // angle accumulator, 2^31 is pi
  localparam int ANGLE_W      = 32;
  localparam int OUT_W        = 16;
  localparam int ATAN_ENTRIES = 32;
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  // cordic gain in q14, used to match z to the scaled length
  localparam int          KGAIN_W    = 16;
  localparam int          KGAIN_FRAC = 14;
  localparam logic [KGAIN_W-1:0] KGAIN_Q14 = 16'd26981;

  localparam logic [ANGLE_W-1:0] ANGLE_PI   = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_ZERO = 32'h0000_0000;
  localparam logic [ANGLE_W-1:0] ROUND_HALF = 32'h0000_8000;

  // pitch is kept within plus or minus half pi
  localparam logic signed [OUT_W-1:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [OUT_W-1:0] PITCH_MIN = -16'sd16384;

  // control that travels with each item down the pipe
  typedef struct packed {
    logic valid;
    logic flag;   // pass one: horizontal vector is zero; pass two: skip pitch
  } ctl_t;

  // atan(2^-i) in accumulator units
  function automatic logic [ANGLE_W-1:0] atan_unit(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      5'd24:   v = 32'h0000_0029;
      5'd25:   v = 32'h0000_0014;
      5'd26:   v = 32'h0000_000A;
      5'd27:   v = 32'h0000_0005;
      5'd28:   v = 32'h0000_0003;
      5'd29:   v = 32'h0000_0001;
      5'd30:   v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/dtyp_prescale.sv
// ----------------------------------------------------------------------------
// dtyp_prescale
// input stage: guard bits, half-plane fold for pass one, z times cordic gain
// ----------------------------------------------------------------------------
`default_nettype none

module dtyp_prescale
  import dtyp_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int W          = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [DATA_WIDTH-1:0] vec_x,
  input  wire logic signed [DATA_WIDTH-1:0] vec_y,
  input  wire logic signed [DATA_WIDTH-1:0] vec_z,
  output ctl_t                              ctl,
  output logic signed [W-1:0]               x,
  output logic signed [W-1:0]               y,
  output logic        [ANGLE_W-1:0]         acc,
  output logic signed [W-1:0]               zs
);

  localparam int PW = DATA_WIDTH + GUARD_BITS + KGAIN_W;

  logic signed [W-1:0]  xe;
  logic signed [W-1:0]  ye;
  logic signed [PW-1:0] ze;
  logic signed [PW-1:0] kg;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;
  logic                 x_neg;

  // sign extend and add guard bits
  assign xe = {{(W-DATA_WIDTH){vec_x[DATA_WIDTH-1]}}, vec_x} <<< GUARD_BITS;
  assign ye = {{(W-DATA_WIDTH){vec_y[DATA_WIDTH-1]}}, vec_y} <<< GUARD_BITS;
  assign ze = {{(PW-DATA_WIDTH){vec_z[DATA_WIDTH-1]}}, vec_z} <<< GUARD_BITS;
  assign kg = {{(PW-KGAIN_W){1'b0}}, KGAIN_Q14};

  // z scaled to the gain of pass one, floor shift
  assign prod    = ze * kg;
  assign prod_sh = prod >>> KGAIN_FRAC;

  assign x_neg = vec_x[DATA_WIDTH-1];

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= in_valid;
      ctl.flag  <= (vec_x == '0) && (vec_y == '0);
    end
  end

  // payload register, left half-plane folded onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      x   <= x_neg ? -xe : xe;
      y   <= x_neg ? -ye : ye;
      acc <= x_neg ? ANGLE_PI : ANGLE_ZERO;
      zs  <= prod_sh[W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: design/dtyp_cordic_stage.sv
// ----------------------------------------------------------------------------
// dtyp_cordic_stage
// one registered vectoring micro-rotation with a fixed shift
// ----------------------------------------------------------------------------
`default_nettype none

module dtyp_cordic_stage
  import dtyp_pkg::*;
#(
  parameter int W      = 25,
  parameter int SIDE_W = 25,
  parameter int SHIFT  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire ctl_t                 ctl_in,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic [ANGLE_W-1:0]   acc_in,
  input  wire logic [SIDE_W-1:0]    side_in,
  output ctl_t                      ctl_out,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic [ANGLE_W-1:0]        acc_out,
  output logic [SIDE_W-1:0]         side_out
);

  localparam logic [ANGLE_W-1:0] ATAN_I = atan_unit(ATAN_IDX_W'(SHIFT));

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic                y_pos;

  assign dx    = y_in >>> SHIFT;
  assign dy    = x_in >>> SHIFT;
  assign y_pos = !y_in[W-1];

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // rotate toward the x axis, both updates from the old x and y
  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= y_pos ? x_in + dx : x_in - dx;
      y_out    <= y_pos ? y_in - dy : y_in + dy;
      acc_out  <= y_pos ? acc_in + ATAN_I : acc_in - ATAN_I;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// File: design/dtyp_cordic_pass.sv
// ----------------------------------------------------------------------------
// dtyp_cordic_pass
// chain of registered vectoring stages, one per iteration
// ----------------------------------------------------------------------------
`default_nettype none

module dtyp_cordic_pass
  import dtyp_pkg::*;
#(
  parameter int W      = 25,
  parameter int SIDE_W = 25,
  parameter int STAGES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire ctl_t                 ctl_in,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic [ANGLE_W-1:0]   acc_in,
  input  wire logic [SIDE_W-1:0]    side_in,
  output ctl_t                      ctl_out,
  output logic signed [W-1:0]       x_out,
  output logic [ANGLE_W-1:0]        acc_out,
  output logic [SIDE_W-1:0]         side_out
);

  ctl_t                ctl_s  [STAGES+1];
  logic signed [W-1:0] x_s    [STAGES+1];
  logic signed [W-1:0] y_s    [STAGES+1];
  logic [ANGLE_W-1:0]  acc_s  [STAGES+1];
  logic [SIDE_W-1:0]   side_s [STAGES+1];

  assign ctl_s[0]  = ctl_in;
  assign x_s[0]    = x_in;
  assign y_s[0]    = y_in;
  assign acc_s[0]  = acc_in;
  assign side_s[0] = side_in;

  // one stage per iteration, shift equal to the iteration number
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    dtyp_cordic_stage #(
      .W      (W),
      .SIDE_W (SIDE_W),
      .SHIFT  (i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl_s[i]),
      .x_in     (x_s[i]),
      .y_in     (y_s[i]),
      .acc_in   (acc_s[i]),
      .side_in  (side_s[i]),
      .ctl_out  (ctl_s[i+1]),
      .x_out    (x_s[i+1]),
      .y_out    (y_s[i+1]),
      .acc_out  (acc_s[i+1]),
      .side_out (side_s[i+1])
    );
  end

  assign ctl_out  = ctl_s[STAGES];
  assign x_out    = x_s[STAGES];
  assign acc_out  = acc_s[STAGES];
  assign side_out = side_s[STAGES];

endmodule

`default_nettype wire

// File: design/dtyp_round.sv
// ----------------------------------------------------------------------------
// dtyp_round
// output stage: round accumulators to 16-bit angles, limit pitch, hold item
// ----------------------------------------------------------------------------
`default_nettype none

module dtyp_round
  import dtyp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire ctl_t                     ctl_in,
  input  wire logic [ANGLE_W-1:0]       yaw_acc,
  input  wire logic [ANGLE_W-1:0]       pitch_acc,
  output logic                          out_valid,
  output logic signed [OUT_W-1:0]       yaw_angle,
  output logic signed [OUT_W-1:0]       pitch_angle
);

  logic [ANGLE_W-1:0]       yaw_r;
  logic [ANGLE_W-1:0]       pitch_r;
  logic signed [OUT_W-1:0]  pitch_raw;
  logic signed [OUT_W-1:0]  pitch_next;

  // round to nearest at bit 16
  assign yaw_r     = yaw_acc + ROUND_HALF;
  assign pitch_r   = pitch_acc + ROUND_HALF;
  assign pitch_raw = pitch_r[ANGLE_W-1 -: OUT_W];

  // zero vector gives level pitch, otherwise limit to the poles
  always_comb begin
    if (ctl_in.flag) begin
      pitch_next = '0;
    end else if (pitch_raw > PITCH_MAX) begin
      pitch_next = PITCH_MAX;
    end else if (pitch_raw < PITCH_MIN) begin
      pitch_next = PITCH_MIN;
    end else begin
      pitch_next = pitch_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_angle   <= yaw_r[ANGLE_W-1 -: OUT_W];
      pitch_angle <= pitch_next;
    end
  end

endmodule

`default_nettype wire

// File: design/direction_to_yaw_pitch_core.sv
// ----------------------------------------------------------------------------
// direction_to_yaw_pitch_core
// 3d direction to yaw and pitch by two chained cordic vectoring passes
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid, in_stall, vec_x/y/z        | in
//   output  | out_valid, out_stall, yaw/pitch_angle| out
//
// one item per cycle unless out_stall holds a result; the pipe holds the input
// stage, one register per iteration in each pass, and the rounding stage
// rst is synchronous and clears only the control bits (valid and flag) of the pipe
// out_stall with a held item freezes every stage and raises in_stall in the
// same cycle; nothing in flight is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module direction_to_yaw_pitch_core
  import dtyp_pkg::*;
#(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] vec_x,
  input  wire logic signed [DATA_WIDTH-1:0] vec_y,
  input  wire logic signed [DATA_WIDTH-1:0] vec_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [OUT_W-1:0]           yaw_angle,
  output logic signed [OUT_W-1:0]           pitch_angle
);

  localparam int W = DATA_WIDTH + GUARD_BITS + GROWTH_BITS;

  logic                en;

  ctl_t                pre_ctl;
  logic signed [W-1:0] pre_x;
  logic signed [W-1:0] pre_y;
  logic [ANGLE_W-1:0]  pre_acc;
  logic signed [W-1:0] pre_zs;

  ctl_t                p1_ctl;
  logic signed [W-1:0] p1_x;
  logic [ANGLE_W-1:0]  p1_acc;
  logic [W-1:0]        p1_side;

  ctl_t                p2_in_ctl;
  logic [ANGLE_W-1:0]  p2_in_side;
  ctl_t                p2_ctl;
  logic signed [W-1:0] p2_x;
  logic [ANGLE_W-1:0]  p2_acc;
  logic [ANGLE_W-1:0]  p2_side;

  // whole pipe advances unless a held result is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // input stage
  dtyp_prescale #(
    .DATA_WIDTH (DATA_WIDTH),
    .W          (W)
  ) u_prescale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .ctl      (pre_ctl),
    .x        (pre_x),
    .y        (pre_y),
    .acc      (pre_acc),
    .zs       (pre_zs)
  );

  // pass one: yaw and scaled horizontal length, z rides along
  dtyp_cordic_pass #(
    .W      (W),
    .SIDE_W (W),
    .STAGES (CORDIC_STAGES)
  ) u_pass_yaw (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (pre_ctl),
    .x_in     (pre_x),
    .y_in     (pre_y),
    .acc_in   (pre_acc),
    .side_in  (pre_zs),
    .ctl_out  (p1_ctl),
    .x_out    (p1_x),
    .acc_out  (p1_acc),
    .side_out (p1_side)
  );

  // zero horizontal vector: yaw is zero; with zero z, pitch is skipped too
  assign p2_in_ctl.valid = p1_ctl.valid;
  assign p2_in_ctl.flag  = p1_ctl.flag && (p1_side == '0);
  assign p2_in_side      = p1_ctl.flag ? ANGLE_ZERO : p1_acc;

  // pass two: pitch from (r, z), yaw rides along
  dtyp_cordic_pass #(
    .W      (W),
    .SIDE_W (ANGLE_W),
    .STAGES (CORDIC_STAGES)
  ) u_pass_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (p2_in_ctl),
    .x_in     (p1_x),
    .y_in     ($signed(p1_side)),
    .acc_in   (ANGLE_ZERO),
    .side_in  (p2_in_side),
    .ctl_out  (p2_ctl),
    .x_out    (p2_x),
    .acc_out  (p2_acc),
    .side_out (p2_side)
  );

  // output stage
  dtyp_round u_round (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ctl_in      (p2_ctl),
    .yaw_acc     (p2_side),
    .pitch_acc   (p2_acc),
    .out_valid   (out_valid),
    .yaw_angle   (yaw_angle),
    .pitch_angle (pitch_angle)
  );

  // final length of pass two is not needed
  logic unused_len;
  assign unused_len = ^p2_x;

  // checks
  `ASSERT_IMPL(a_pitch_range, clk, rst, out_valid, (pitch_angle <= PITCH_MAX) && (pitch_angle >= PITCH_MIN))
  `ASSERT_IMPL(a_stall_only_when_held, clk, rst, in_stall, out_valid)
  `ASSERT_NEXT(a_reset_empties, clk, 1'b0, rst, !out_valid)

endmodule

`default_nettype wire

// File: bench/tb_direction_to_yaw_pitch_core.sv
// ----------------------------------------------------------------------------
// tb_direction_to_yaw_pitch_core
// self-checking bench for the direction to yaw/pitch cordic pipeline
//
// a queue of direction vectors (directed corner cases, then random mixes)
// feeds a burst/gap driver; every accepted item is run through a bit-exact
// model of the two vectoring passes and the expected angle pair is queued.
// a monitor compares each accepted result with the oldest expected pair
// while the receiver stalls on its own pattern, with one long hold-off
// that backs the pipe up into its input
// ----------------------------------------------------------------------------
`default_nettype none

module tb_direction_to_yaw_pitch_core
  import dtyp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW         = 16;
  localparam int STAGES     = 16;
  localparam int LATENCY    = 2 * STAGES + 2;
  localparam int N_RANDOM   = 750;
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_LEN   = 150;
  localparam int HOLD_AFTER = 300;
  localparam int MAX_REPORT = 30;

  // atan(2^-i) in accumulator units, entry 0 in the top word
  localparam logic [32*32-1:0] ATAN_BITS = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } dir_vec_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] yaw;
    logic signed [OUT_W-1:0] pitch;
  } angle_pair_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [DW-1:0]    vec_x = '0;
  logic signed [DW-1:0]    vec_y = '0;
  logic signed [DW-1:0]    vec_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] yaw_angle;
  logic signed [OUT_W-1:0] pitch_angle;

  dir_vec_t    vec_queue[$];
  angle_pair_t angle_queue[$];
  dir_vec_t    cur_vec;

  bit item_taken = 1'b0;
  int burst_left = 8;
  int gap_left   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int cycles     = 0;
  int n_in       = 0;
  int n_out      = 0;
  int n_err      = 0;
  int n_backed   = 0;

  direction_to_yaw_pitch_core #(
    .DATA_WIDTH   (DW),
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .yaw_angle  (yaw_angle),
    .pitch_angle(pitch_angle)
  );

  // ------------------------------------------------------------------------
  // angle model
  // ------------------------------------------------------------------------

  // one vectoring pass, drives py toward zero and returns the accumulator
  function automatic logic [ANGLE_W-1:0] vector_pass(inout longint px, inout longint py,
                                                     input logic [ANGLE_W-1:0] acc);
    longint dx;
    longint dy;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px  = px + dx;
        py  = py - dy;
        acc = acc + ATAN_BITS[(ATAN_ENTRIES-1-i)*32 +: 32];
      end else begin
        px  = px - dx;
        py  = py + dy;
        acc = acc - ATAN_BITS[(ATAN_ENTRIES-1-i)*32 +: 32];
      end
    end
    return acc;
  endfunction

  // round the 32-bit accumulator to a 16-bit angle
  function automatic logic signed [OUT_W-1:0] round_angle(input logic [ANGLE_W-1:0] acc);
    logic [ANGLE_W-1:0] t;
    t = acc + ROUND_HALF;
    return t[ANGLE_W-1 -: OUT_W];
  endfunction

  function automatic angle_pair_t dir_to_angles(input dir_vec_t v);
    longint             x;
    longint             y;
    longint             z;
    longint             r;
    longint             zs;
    longint             px;
    longint             py;
    logic [ANGLE_W-1:0] yaw_acc;
    logic [ANGLE_W-1:0] pitch_acc;
    int                 p;
    angle_pair_t        res;
    x = longint'(v.x) <<< GUARD_BITS;
    y = longint'(v.y) <<< GUARD_BITS;
    z = longint'(v.z) <<< GUARD_BITS;
    yaw_acc   = ANGLE_ZERO;
    pitch_acc = ANGLE_ZERO;
    // pass one: yaw and scaled horizontal length
    if (x == 0 && y == 0) begin
      r = 0;
    end else begin
      if (x < 0) begin
        x       = -x;
        y       = -y;
        yaw_acc = ANGLE_PI;
      end
      yaw_acc = vector_pass(x, y, yaw_acc);
      r = x;
    end
    // pass two: z brought to the same gain as r
    zs = (z * longint'(KGAIN_Q14)) >>> KGAIN_FRAC;
    if (!(r == 0 && zs == 0)) begin
      px = r;
      py = zs;
      pitch_acc = vector_pass(px, py, ANGLE_ZERO);
    end
    // pitch limited to half pi either way
    p = int'(round_angle(pitch_acc));
    if (p > PITCH_MAX) p = PITCH_MAX;
    if (p < PITCH_MIN) p = PITCH_MIN;
    res.yaw   = (x == 0 && y == 0 && yaw_acc == ANGLE_ZERO) ? '0 : round_angle(yaw_acc);
    res.pitch = p[OUT_W-1:0];
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  function automatic logic signed [DW-1:0] any_comp();
    return DW'($urandom());
  endfunction

  function automatic logic signed [DW-1:0] tiny_comp();
    return DW'($urandom_range(0, 32) - 16);
  endfunction

  function automatic logic signed [DW-1:0] edge_comp();
    case ($urandom_range(0, 6))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic dir_vec_t mk_vec(input logic signed [DW-1:0] x,
                                      input logic signed [DW-1:0] y,
                                      input logic signed [DW-1:0] z);
    dir_vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // clock, reset, cycle limit
  // ------------------------------------------------------------------------

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               angle_queue.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // item sources
  // ------------------------------------------------------------------------

  initial begin
    dir_vec_t v;
    // zero vector and zero horizontal vector with z at its extremes and at plus or minus one
    vec_queue.push_back(mk_vec(16'sd0, 16'sd0, 16'sd0));
    vec_queue.push_back(mk_vec(16'sd0, 16'sd0, 16'sd32767));
    vec_queue.push_back(mk_vec(16'sd0, 16'sd0, -16'sd32768));
    vec_queue.push_back(mk_vec(16'sd0, 16'sd0, 16'sd1));
    vec_queue.push_back(mk_vec(16'sd0, 16'sd0, -16'sd1));
    // axes and one diagonal, negative x takes the half-turn start
    vec_queue.push_back(mk_vec(16'sd32767, 16'sd0, 16'sd0));
    vec_queue.push_back(mk_vec(-16'sd32768, 16'sd0, 16'sd0));
    vec_queue.push_back(mk_vec(-16'sd1, 16'sd0, 16'sd0));
    vec_queue.push_back(mk_vec(16'sd1, 16'sd0, 16'sd0));
    vec_queue.push_back(mk_vec(16'sd0, 16'sd32767, 16'sd0));
    vec_queue.push_back(mk_vec(16'sd0, -16'sd32768, 16'sd0));
    vec_queue.push_back(mk_vec(16'sd0, 16'sd1, 16'sd0));
    vec_queue.push_back(mk_vec(-16'sd1, -16'sd1, 16'sd0));
    // corners of the cube
    vec_queue.push_back(mk_vec(16'sd32767, 16'sd32767, 16'sd32767));
    vec_queue.push_back(mk_vec(-16'sd32768, -16'sd32768, -16'sd32768));
    vec_queue.push_back(mk_vec(-16'sd32768, 16'sd32767, 16'sd32767));
    vec_queue.push_back(mk_vec(16'sd32767, -16'sd32768, -16'sd32768));
    // near the poles, tiny horizontal part under a large z
    vec_queue.push_back(mk_vec(16'sd1, 16'sd0, 16'sd32767));
    vec_queue.push_back(mk_vec(-16'sd1, 16'sd1, -16'sd32768));
    vec_queue.push_back(mk_vec(16'sd0, -16'sd1, 16'sd32767));
    // large horizontal, tiny z
    vec_queue.push_back(mk_vec(-16'sd32768, -16'sd1, 16'sd1));
    vec_queue.push_back(mk_vec(16'sd23170, 16'sd23170, -16'sd1));

    // random mixes, weighted toward the awkward regions
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = mk_vec(any_comp(), any_comp(), any_comp());
        4:          v = mk_vec(tiny_comp(), tiny_comp(), tiny_comp());
        5:          v = mk_vec(16'sd0, 16'sd0, any_comp());
        6:          v = mk_vec(tiny_comp(), tiny_comp(), any_comp());
        7: begin
          v = mk_vec(any_comp(), any_comp(), any_comp());
          if ($urandom_range(0, 1)) v.x = '0;
          else v.y = '0;
        end
        8:          v = mk_vec(edge_comp(), edge_comp(), edge_comp());
        default:    v = mk_vec(any_comp(), any_comp(), tiny_comp());
      endcase
      vec_queue.push_back(v);
    end

    // drain: all items in, all results out, then the pipe's depth
    @(negedge rst);
    while (vec_queue.size() > 0 || in_valid) @(posedge clk);
    while (angle_queue.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("run covered %0d direction vectors, %0d angle pairs checked, %0d mismatches",
             n_in, n_out, n_err);
    $display("input held back on %0d cycles, long receiver hold-off %0s", n_backed,
             hold_done ? "done" : "not reached");
    if (n_err == 0 && angle_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // driver: bursts of items with random gaps
  // ------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !item_taken) begin
        // item still waiting, hold it
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (vec_queue.size() > 0) begin
        cur_vec = vec_queue.pop_front();
        vec_x    <= cur_vec.x;
        vec_y    <= cur_vec.y;
        vec_z    <= cur_vec.z;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  // ------------------------------------------------------------------------
  // receiver: stall pattern in stretches, plus one long hold-off
  // ------------------------------------------------------------------------

  always @(negedge clk) begin
    bit stall_now;
    stall_now = 1'b0;
    if (hold_left > 0) begin
      stall_now = 1'b1;
      hold_left--;
    end else if (!hold_done && n_in >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      stall_now = 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 80);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       stall_now = 1'b0;
        1:       stall_now = ($urandom_range(0, 3) == 0);
        2:       stall_now = ($urandom_range(0, 9) < 7);
        default: stall_now = ($urandom_range(0, 1) == 0);
      endcase
    end
    out_stall <= stall_now;
  end

  // ------------------------------------------------------------------------
  // monitor: predict on input accept, check on output accept
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    angle_pair_t want;
    if (!rst) begin
      // accepted item gives its expected angle pair
      if (in_valid && !in_stall) begin
        angle_queue.push_back(dir_to_angles(mk_vec(vec_x, vec_y, vec_z)));
        item_taken = 1'b1;
        n_in++;
      end
      if (in_valid && in_stall) n_backed++;

      // accepted result against the oldest expectation
      if (out_valid && !out_stall) begin
        n_out++;
        if (angle_queue.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORT)
            $display("%0t: result with nothing expected: yaw %0d pitch %0d", $time,
                     yaw_angle, pitch_angle);
        end else begin
          want = angle_queue.pop_front();
          if (yaw_angle !== want.yaw) begin
            n_err++;
            if (n_err <= MAX_REPORT)
              $display("%0t: yaw_angle mismatch, expected %0d, got %0d", $time,
                       want.yaw, yaw_angle);
          end
          if (pitch_angle !== want.pitch) begin
            n_err++;
            if (n_err <= MAX_REPORT)
              $display("%0t: pitch_angle mismatch, expected %0d, got %0d", $time,
                       want.pitch, pitch_angle);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
